### hdl/pac_pkg.sv
// Package for the peak audio compressor: widths, register codes, reset values
// and the request types shared by the top level and its serial units.
// No dependencies.
`timescale 1ns / 1ps

package pac_pkg;

  localparam int NUM_CH      = 8;
  localparam int CH_IDX_W    = $clog2(NUM_CH);
  localparam int CH_CNT_W    = CH_IDX_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int ENV_BITS    = 24;
  localparam int ENV_SHIFT   = ENV_BITS - SAMPLE_BITS;
  localparam int COEF_BITS   = 16;
  localparam int GAIN_BITS   = 16;
  localparam int RATIO_BITS  = 16;
  localparam int THR_BITS    = 16;
  localparam int CEIL_BITS   = 15;

  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = GAIN_BITS'(32768);
  localparam logic [RATIO_BITS-1:0] RATIO_UNITY = RATIO_BITS'(256);

  // bit-serial divider
  localparam int DIV_BITS   = 24;
  localparam int DIV_STEP_W = 5;
  localparam logic [DIV_STEP_W-1:0] DIV1_STEPS = DIV_STEP_W'(24);
  localparam logic [DIV_STEP_W-1:0] DIV2_STEPS = DIV_STEP_W'(16);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS  = 3'd0,
    REG_ATTACK    = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_RATIO     = 3'd4,
    REG_CEILING   = 3'd5
  } cfg_reg_e;

  localparam logic [CH_CNT_W-1:0]   RST_CHANNELS  = CH_CNT_W'(2);
  localparam logic [COEF_BITS-1:0]  RST_ATTACK    = COEF_BITS'(63000);
  localparam logic [COEF_BITS-1:0]  RST_RELEASE   = COEF_BITS'(65400);
  localparam logic [THR_BITS-1:0]   RST_THRESHOLD = THR_BITS'(16384);
  localparam logic [RATIO_BITS-1:0] RST_RATIO     = RATIO_BITS'(1024);
  localparam logic [CEIL_BITS-1:0]  RST_CEILING   = CEIL_BITS'(32767);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NUM_CH-1:0] frame_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_BITS-1:0]   rem_init;
    logic [DIV_BITS-1:0]   divisor;
    logic [DIV_BITS-1:0]   shift_in;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                done;
    logic [ENV_BITS-1:0] level;
  } env_rsp_t;

endpackage

### hdl/pac_if.sv
// Channel interfaces of the peak audio compressor: frame input, result output
// and configuration write. Depends on pac_pkg.
`timescale 1ns / 1ps

interface pac_in_if import pac_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_ch0;
  sample_t in_ch1;
  sample_t in_ch2;
  sample_t in_ch3;
  sample_t in_ch4;
  sample_t in_ch5;
  sample_t in_ch6;
  sample_t in_ch7;

  modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                  in_ch6, in_ch7, input ready);
  modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                in_ch6, in_ch7, output ready);
endinterface

interface pac_out_if import pac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  sample_t              out_ch0;
  sample_t              out_ch1;
  sample_t              out_ch2;
  sample_t              out_ch3;
  sample_t              out_ch4;
  sample_t              out_ch5;
  sample_t              out_ch6;
  sample_t              out_ch7;
  logic [GAIN_BITS-1:0] applied_gain;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                  out_ch6, out_ch7, applied_gain, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                out_ch6, out_ch7, applied_gain, output ready);
endinterface

interface pac_cfg_if import pac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/pac_env.sv
// Peak scan over the channels in use and envelope follower with a
// bit-serial coefficient multiply. Depends on pac_pkg.
`timescale 1ns / 1ps

module pac_env import pac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  frame_t               frame_i,
  input  logic [CH_IDX_W-1:0]  last_ch_i,
  input  logic [COEF_BITS-1:0] attack_i,
  input  logic [COEF_BITS-1:0] release_i,
  output env_rsp_t             rsp_o
);

  typedef enum logic [1:0] {E_IDLE, E_SCAN, E_MUL, E_SUM} env_state_e;

  localparam int DIFF_W = ENV_BITS + 1;
  localparam int ACC_W  = ENV_BITS + 2;
  localparam int BIT_W  = $clog2(COEF_BITS);

  env_state_e                 state_q;
  logic [CH_IDX_W-1:0]        idx_q;
  logic [SAMPLE_BITS-1:0]     peak_q;
  logic [COEF_BITS-1:0]       coef_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [BIT_W-1:0]           bit_q;
  logic [ENV_BITS-1:0]        env_q;
  logic                       done_q;

  logic [SAMPLE_BITS-1:0]     smp_u;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [SAMPLE_BITS-1:0]     peak_max;
  logic [ENV_BITS-1:0]        peak_wide;
  logic [ENV_BITS-1:0]        peak_held;
  logic signed [ACC_W:0]      mul_sum;
  logic [ACC_W-1:0]           env_sum;

  // magnitude of the current channel and running maximum
  always_comb begin
    smp_u     = frame_i[idx_q];
    mag       = smp_u[SAMPLE_BITS-1] ? (~smp_u + 1'b1) : smp_u;
    peak_max  = (mag > peak_q) ? mag : peak_q;
    peak_wide = {peak_max, {ENV_SHIFT{1'b0}}};
    peak_held = {peak_q, {ENV_SHIFT{1'b0}}};
  end

  // one coefficient bit per cycle, LSB first, dropping the low product bits
  always_comb begin
    mul_sum = {acc_q[ACC_W-1], acc_q}
            + (coef_q[0] ? {{2{diff_q[DIFF_W-1]}}, diff_q} : '0);
    env_sum = ACC_W'(acc_q) + {2'b00, peak_held};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      env_q   <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      done_q <= (state_q == E_SUM);
      case (state_q)
        E_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            peak_q  <= '0;
            state_q <= E_SCAN;
          end
        end
        E_SCAN: begin
          peak_q <= peak_max;
          idx_q  <= idx_q + 1'b1;
          if (idx_q == last_ch_i) begin
            // new level is the peak plus coef times (env - peak), floored
            coef_q  <= (peak_wide > env_q) ? attack_i : release_i;
            diff_q  <= $signed({1'b0, env_q}) - $signed({1'b0, peak_wide});
            acc_q   <= '0;
            bit_q   <= '0;
            state_q <= E_MUL;
          end
        end
        E_MUL: begin
          acc_q  <= mul_sum[ACC_W:1];
          coef_q <= coef_q >> 1;
          bit_q  <= bit_q + 1'b1;
          if (bit_q == BIT_W'(COEF_BITS - 1)) begin
            state_q <= E_SUM;
          end
        end
        E_SUM: begin
          env_q   <= env_sum[ENV_BITS-1:0];
          state_q <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.level = env_q;

endmodule

### hdl/pac_div.sv
// Restoring divider, one quotient bit per cycle; the dividend arrives as a
// starting remainder plus a word of bits shifted in MSB first. Depends on pac_pkg.
`timescale 1ns / 1ps

module pac_div import pac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic [DIV_BITS-1:0]   rem_q;
  logic [DIV_BITS-1:0]   sh_q;
  logic [DIV_BITS-1:0]   dvs_q;
  logic [DIV_BITS-1:0]   quot_q;

  logic [DIV_BITS+1:0]   trial;
  logic                  fits;
  logic [DIV_BITS-1:0]   rem_d;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {1'b0, rem_q, sh_q[DIV_BITS-1]} - {2'b00, dvs_q};
    fits  = ~trial[DIV_BITS+1];
    rem_d = fits ? trial[DIV_BITS-1:0] : {rem_q[DIV_BITS-2:0], sh_q[DIV_BITS-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_STEP_W'(1));
      if (busy_q) begin
        rem_q  <= rem_d;
        sh_q   <= sh_q << 1;
        quot_q <= {quot_q[DIV_BITS-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end else if (req_i.start) begin
        rem_q  <= req_i.rem_init;
        sh_q   <= req_i.shift_in;
        dvs_q  <= req_i.divisor;
        quot_q <= '0;
        cnt_q  <= req_i.steps;
        busy_q <= 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### hdl/pac_scale.sv
// Gain lanes: one bit-serial multiply per channel, gain LSB first, then the
// ceiling clamp and the zeroing of unused channels. Depends on pac_pkg.
`timescale 1ns / 1ps

module pac_scale import pac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  frame_t               frame_i,
  input  logic [GAIN_BITS-1:0] gain_i,
  input  logic [CH_IDX_W-1:0]  last_ch_i,
  input  logic [CEIL_BITS-1:0] ceiling_i,
  output logic                 done_o,
  output frame_t               result_o
);

  localparam int ACC_W = SAMPLE_BITS + 2;
  localparam int CNT_W = $clog2(GAIN_BITS);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [GAIN_BITS-1:0]     g_q;
  logic signed [ACC_W-1:0]  acc_q [NUM_CH];
  frame_t                   res_q;

  logic signed [ACC_W:0]    sum   [NUM_CH];
  sample_t                  clamp [NUM_CH];
  logic signed [ACC_W:0]    ceil_pos;
  logic signed [ACC_W:0]    ceil_neg;

  // per-lane add and clamp
  always_comb begin
    ceil_pos = $signed({{(ACC_W + 1 - CEIL_BITS){1'b0}}, ceiling_i});
    ceil_neg = -ceil_pos;
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = (ACC_W + 1)'(acc_q[i])
             + (g_q[0] ? (ACC_W + 1)'(frame_i[i]) : '0);
      if (CH_CNT_W'(i) > {1'b0, last_ch_i}) begin
        clamp[i] = '0;
      end else if (sum[i] > ceil_pos) begin
        clamp[i] = SAMPLE_BITS'(ceil_pos);
      end else if (sum[i] < ceil_neg) begin
        clamp[i] = SAMPLE_BITS'(ceil_neg);
      end else begin
        clamp[i] = SAMPLE_BITS'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(GAIN_BITS - 1));
      if (busy_q) begin
        g_q   <= g_q >> 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(GAIN_BITS - 1)) begin
          // top gain bit: add without the halving, then clamp
          for (int i = 0; i < NUM_CH; i++) begin
            res_q[i] <= clamp[i];
          end
          busy_q <= 1'b0;
        end else begin
          for (int i = 0; i < NUM_CH; i++) begin
            acc_q[i] <= sum[i][ACC_W:1];
          end
        end
      end else if (start_i) begin
        g_q    <= gain_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        for (int i = 0; i < NUM_CH; i++) begin
          acc_q[i] <= '0;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### hdl/peak_audio_compressor.sv
// Top level of the peak audio compressor: configuration registers, frame
// sequencer and output register. Depends on pac_pkg, pac_if, pac_env,
// pac_div and pac_scale.
//
//   port      dir  handshake      payload
//   frame_i   in   valid/ready    in_ch0..in_ch7, Q1.15 samples
//   result_o  out  valid/ready    out_ch0..out_ch7, applied_gain
//   cfg_i     in   valid/ready    index, data (register write)
//
// A frame runs the channel scan, the 16-step serial envelope multiply and
// the 16-step gain lanes one after another; when the envelope sits above the
// threshold, the 24- and 16-step bit-serial divides run between the multiply
// and the gain lanes. Reset clears the envelope and loads the register
// defaults. A stalled result waits in the output register while the next
// frame is accepted and processed.
`timescale 1ns / 1ps

module peak_audio_compressor import pac_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  pac_in_if.sink    frame_i,
  pac_out_if.source result_o,
  pac_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {S_IDLE, S_ENV, S_DIV1, S_DIV2, S_SCALE, S_DONE} state_e;

  state_e                state_q;
  logic [CH_CNT_W-1:0]   channels_q;
  logic [COEF_BITS-1:0]  attack_q;
  logic [COEF_BITS-1:0]  release_q;
  logic [THR_BITS-1:0]   threshold_q;
  logic [RATIO_BITS-1:0] ratio_q;
  logic [CEIL_BITS-1:0]  ceiling_q;

  frame_t                frame_q;
  logic                  env_start_q;
  logic                  scale_start_q;
  div_req_t              div_req_q;
  logic [GAIN_BITS-1:0]  gain_q;
  frame_t                out_frame_q;
  logic [GAIN_BITS-1:0]  out_gain_q;
  logic                  out_valid_q;

  env_rsp_t              env_rsp;
  div_rsp_t              div_rsp;
  logic                  scale_done;
  frame_t                scale_res;

  logic [CH_IDX_W-1:0]   last_ch;
  logic [ENV_BITS-1:0]   thr_wide;
  logic [RATIO_BITS-1:0] ratio_eff;
  logic [ENV_BITS-1:0]   env_over;
  logic [ENV_BITS-1:0]   knee_level;
  logic                  unity;
  logic                  out_free;

  // effective channel count, threshold and ratio
  always_comb begin
    if (channels_q == '0) begin
      last_ch = '0;
    end else if (channels_q > CH_CNT_W'(NUM_CH)) begin
      last_ch = CH_IDX_W'(NUM_CH - 1);
    end else begin
      last_ch = CH_IDX_W'(channels_q - 1'b1);
    end
    thr_wide   = {threshold_q, {ENV_SHIFT{1'b0}}};
    ratio_eff  = (ratio_q < RATIO_UNITY) ? RATIO_UNITY : ratio_q;
    env_over   = env_rsp.level - thr_wide;
    knee_level = thr_wide + div_rsp.quot;
    unity      = (env_rsp.level == '0) || (env_rsp.level <= thr_wide);
    out_free   = !out_valid_q || result_o.ready;
  end

  // configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q  <= RST_CHANNELS;
      attack_q    <= RST_ATTACK;
      release_q   <= RST_RELEASE;
      threshold_q <= RST_THRESHOLD;
      ratio_q     <= RST_RATIO;
      ceiling_q   <= RST_CEILING;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CHANNELS:  channels_q  <= cfg_i.data[CH_CNT_W-1:0];
        REG_ATTACK:    attack_q    <= cfg_i.data[COEF_BITS-1:0];
        REG_RELEASE:   release_q   <= cfg_i.data[COEF_BITS-1:0];
        REG_THRESHOLD: threshold_q <= cfg_i.data[THR_BITS-1:0];
        REG_RATIO:     ratio_q     <= cfg_i.data[RATIO_BITS-1:0];
        REG_CEILING:   ceiling_q   <= cfg_i.data[CEIL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign frame_i.ready = (state_q == S_IDLE);

  // frame sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      env_start_q     <= 1'b0;
      scale_start_q   <= 1'b0;
      div_req_q.start <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      // one-cycle start pulses for the serial units
      env_start_q     <= (state_q == S_IDLE) && frame_i.valid;
      scale_start_q   <= ((state_q == S_ENV) && env_rsp.done && unity)
                       || ((state_q == S_DIV2) && div_rsp.done);
      div_req_q.start <= ((state_q == S_ENV) && env_rsp.done && !unity)
                       || ((state_q == S_DIV1) && div_rsp.done);
      // raise on hand-over, drop once the request is taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (frame_i.valid) begin
            frame_q     <= {frame_i.in_ch7, frame_i.in_ch6, frame_i.in_ch5, frame_i.in_ch4,
                            frame_i.in_ch3, frame_i.in_ch2, frame_i.in_ch1, frame_i.in_ch0};
            state_q     <= S_ENV;
          end
        end
        S_ENV: begin
          if (env_rsp.done) begin
            if (unity) begin
              gain_q        <= GAIN_UNITY;
              state_q       <= S_SCALE;
            end else begin
              // excess over threshold times 256, divided by the ratio
              div_req_q.rem_init <= DIV_BITS'(env_over[ENV_BITS-1:16]);
              div_req_q.divisor  <= DIV_BITS'(ratio_eff);
              div_req_q.shift_in <= {env_over[15:0], 8'h00};
              div_req_q.steps    <= DIV1_STEPS;
              state_q            <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            // knee level times 32768, divided by the envelope
            div_req_q.rem_init <= {1'b0, knee_level[ENV_BITS-1:1]};
            div_req_q.divisor  <= DIV_BITS'(env_rsp.level);
            div_req_q.shift_in <= {knee_level[0], {(DIV_BITS - 1){1'b0}}};
            div_req_q.steps    <= DIV2_STEPS;
            state_q            <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            gain_q        <= div_rsp.quot[GAIN_BITS-1:0];
            state_q       <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (scale_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (out_free) begin
            out_frame_q <= scale_res;
            out_gain_q  <= gain_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  pac_env u_env (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (env_start_q),
    .frame_i   (frame_q),
    .last_ch_i (last_ch),
    .attack_i  (attack_q),
    .release_i (release_q),
    .rsp_o     (env_rsp)
  );

  pac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  pac_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scale_start_q),
    .frame_i   (frame_q),
    .gain_i    (gain_q),
    .last_ch_i (last_ch),
    .ceiling_i (ceiling_q),
    .done_o    (scale_done),
    .result_o  (scale_res)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.out_ch0      = out_frame_q[0];
  assign result_o.out_ch1      = out_frame_q[1];
  assign result_o.out_ch2      = out_frame_q[2];
  assign result_o.out_ch3      = out_frame_q[3];
  assign result_o.out_ch4      = out_frame_q[4];
  assign result_o.out_ch5      = out_frame_q[5];
  assign result_o.out_ch6      = out_frame_q[6];
  assign result_o.out_ch7      = out_frame_q[7];
  assign result_o.applied_gain = out_gain_q;

  // serial units report back only in the state that waits for them
  a_env_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_rsp.done |-> state_q == S_ENV)
    else $error("envelope done outside its wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider done outside a divide state");

  a_scale_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> state_q == S_SCALE)
    else $error("gain lanes done outside the scale state");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.applied_gain <= GAIN_UNITY)
    else $error("applied gain above unity");

endmodule
